@@ hw/rtl/bsi_pkg.sv @@
package bsi_pkg;

  localparam int unsigned MaxBoxesDef  = 64;
  localparam int unsigned CoordBitsDef = 15;
  localparam int unsigned RatioW       = 17;
  localparam int unsigned ClassW       = 8;
  localparam int unsigned ModeW        = 2;

  localparam logic [RatioW-1:0] ThresholdReset = 17'd26214;
  localparam logic [RatioW-1:0] RatioOne       = 17'h10000;

  typedef enum logic [ModeW-1:0] {
    ModeTruth = 2'd0,
    ModeGuess = 2'd1,
    ModeEval  = 2'd2,
    ModeNone  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    StIdle,
    StSortChk,
    StSortCap,
    StSortCmp,
    StSortWb,
    StPairChk,
    StPairGeo,
    StPairMul,
    StPairUni,
    StPairDivSt,
    StPairDiv,
    StDivMean,
    StDivRec,
    StDivPrec
  } state_e;

  typedef enum logic [4:0] {
    OpNone,
    OpLoad,
    OpEvalInit,
    OpSortRdi,
    OpSortCap,
    OpSortCmp,
    OpSortWb,
    OpNextSet,
    OpPairInit,
    OpPairRd,
    OpPairGeo,
    OpPairMul,
    OpPairUni,
    OpPairDivSt,
    OpPairSkip,
    OpPairAcc,
    OpFinMean,
    OpFinRec,
    OpFinPrec,
    OpEmit
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic sort_more;
    logic j_last;
    logic first_set;
    logic pair_more;
    logic empty;
    logic div_busy;
    logic out_block;
  } dp_status_t;

endpackage

@@ hw/rtl/bsi_ram.sv @@
module bsi_ram #(
  parameter int unsigned Width = 68,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bsi_div.sv @@
module bsi_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 33,
  parameter int unsigned QuotW = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  output logic             busy_o,
  output logic [QuotW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [NumW-1:0]  num_q;
  logic [DenW-1:0]  den_q;
  logic [DenW-1:0]  rem_q;
  logic [QuotW-1:0] quot_q;
  logic [DenW:0]    shift;
  logic             fits;

  assign shift = {rem_q, num_q[NumW-1]};
  assign fits  = shift >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(NumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NumW-2:0], 1'b0};
      rem_q  <= fits ? DenW'(shift - {1'b0, den_q}) : shift[DenW-1:0];
      quot_q <= {quot_q[QuotW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

@@ hw/rtl/bsi_datapath.sv @@
module bsi_datapath #(
  parameter int unsigned MaxBoxes  = bsi_pkg::MaxBoxesDef,
  parameter int unsigned CoordBits = bsi_pkg::CoordBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bsi_pkg::dp_cmd_t                    cmd_i,
  output bsi_pkg::dp_status_t                 status_o,
  input  logic [bsi_pkg::ModeW-1:0]           mode_i,
  input  logic [bsi_pkg::ClassW-1:0]          class_id_i,
  input  logic signed [CoordBits-1:0]         x_min_i,
  input  logic signed [CoordBits-1:0]         y_min_i,
  input  logic signed [CoordBits-1:0]         x_max_i,
  input  logic signed [CoordBits-1:0]         y_max_i,
  input  logic                                iou_threshold_we_i,
  input  logic [bsi_pkg::RatioW-1:0]          iou_threshold_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [bsi_pkg::RatioW-1:0]          mean_iou_o,
  output logic [bsi_pkg::RatioW-1:0]          recall_ratio_o,
  output logic [bsi_pkg::RatioW-1:0]          precision_ratio_o,
  output logic [$clog2(MaxBoxes+1)-1:0]       match_count_o,
  output logic [$clog2(MaxBoxes+1)-1:0]       scored_pairs_o
);
  import bsi_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxBoxes + 1);
  localparam int unsigned IdxW  = $clog2(MaxBoxes);
  localparam int unsigned EntW  = 4 * CoordBits + ClassW;
  localparam int unsigned SpanW = CoordBits + 1;
  localparam int unsigned AreaW = 2 * SpanW;
  localparam int unsigned UniW  = AreaW + 1;
  localparam int unsigned NumW  = AreaW + 16;
  localparam int unsigned SumW  = CntW + RatioW;

  function automatic logic [SpanW-1:0] span_f(input logic [CoordBits-1:0] lo,
                                              input logic [CoordBits-1:0] hi);
    logic signed [CoordBits:0] d;
    d = $signed({hi[CoordBits-1], hi}) - $signed({lo[CoordBits-1], lo});
    if (d[CoordBits]) begin
      d = -d;
    end
    span_f = SpanW'(d) + SpanW'(1);
  endfunction

  function automatic logic signed [CoordBits-1:0] fld(input logic [EntW-1:0] e,
                                                     input int unsigned k);
    fld = $signed(e[k*CoordBits +: CoordBits]);
  endfunction

  logic [RatioW-1:0] thr_q;
  logic [CntW-1:0]   nt_q, ng_q, i_q, j_q;
  logic              set_q;
  logic [EntW-1:0]   cur_q;
  logic              empty_q, disj_q, cls_eq_q;
  logic [SpanW-1:0]  iw_q, ih_q, aw_q, ah_q, bw_q, bh_q;
  logic [AreaW-1:0]  inter_q, aa_q, ab_q;
  logic [UniW-1:0]   uni_q;
  logic [SumW-1:0]   sum_q;
  logic [CntW-1:0]   scored_q, matches_q;
  logic [RatioW-1:0] mean_q, rec_q;
  logic              out_valid_q;
  logic [RatioW-1:0] o_mean_q, o_rec_q, o_prec_q;
  logic [CntW-1:0]   o_match_q, o_scored_q;

  logic [EntW-1:0]   t_rd, g_rd, rd, wdata;
  logic              t_we, g_we, swap;
  logic [IdxW-1:0]   waddr, raddr;
  logic [CntW-1:0]   n_sel, pairs, j_next;
  logic              div_start, div_busy;
  logic [NumW-1:0]   div_num;
  logic [UniW-1:0]   div_den;
  logic [RatioW-1:0] quot, q_pair;
  logic signed [CoordBits-1:0] x1, y1, x2, y2;

  assign n_sel  = set_q ? ng_q : nt_q;
  assign pairs  = (nt_q < ng_q) ? nt_q : ng_q;
  assign rd     = set_q ? g_rd : t_rd;
  assign j_next = j_q + CntW'(1);
  assign swap   = fld(cur_q, 0) < fld(rd, 0);

  always_comb begin
    t_we  = 1'b0;
    g_we  = 1'b0;
    waddr = i_q[IdxW-1:0];
    wdata = cur_q;
    raddr = i_q[IdxW-1:0];
    unique case (cmd_i.op)
      OpLoad: begin
        wdata = {class_id_i, y_max_i, x_max_i, y_min_i, x_min_i};
        if (mode_i == ModeTruth) begin
          waddr = nt_q[IdxW-1:0];
          t_we  = nt_q < CntW'(MaxBoxes);
        end else begin
          waddr = ng_q[IdxW-1:0];
          g_we  = ng_q < CntW'(MaxBoxes);
        end
      end
      OpSortCap: raddr = j_q[IdxW-1:0];
      OpSortCmp: begin
        raddr = j_next[IdxW-1:0];
        waddr = j_q[IdxW-1:0];
        t_we  = swap && !set_q;
        g_we  = swap && set_q;
      end
      OpSortWb: begin
        t_we = !set_q;
        g_we = set_q;
      end
      default: ;
    endcase
  end

  bsi_ram #(.Width(EntW), .Depth(MaxBoxes)) u_truth_ram (
    .clk_i, .we_i(t_we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(t_rd)
  );

  bsi_ram #(.Width(EntW), .Depth(MaxBoxes)) u_guess_ram (
    .clk_i, .we_i(g_we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(g_rd)
  );

  assign x1 = (fld(t_rd, 0) > fld(g_rd, 0)) ? fld(t_rd, 0) : fld(g_rd, 0);
  assign y1 = (fld(t_rd, 1) > fld(g_rd, 1)) ? fld(t_rd, 1) : fld(g_rd, 1);
  assign x2 = (fld(t_rd, 2) < fld(g_rd, 2)) ? fld(t_rd, 2) : fld(g_rd, 2);
  assign y2 = (fld(t_rd, 3) < fld(g_rd, 3)) ? fld(t_rd, 3) : fld(g_rd, 3);

  always_comb begin
    div_start = 1'b0;
    div_num   = {inter_q, 16'h0};
    div_den   = uni_q;
    unique case (cmd_i.op)
      OpPairDivSt: div_start = 1'b1;
      OpFinMean: begin
        div_start = 1'b1;
        div_num   = NumW'(sum_q);
        div_den   = (scored_q == '0) ? UniW'(1) : UniW'(scored_q);
      end
      OpFinRec: begin
        div_start = 1'b1;
        div_num   = NumW'({matches_q, 16'h0});
        div_den   = (nt_q == '0) ? UniW'(1) : UniW'(nt_q);
      end
      OpFinPrec: begin
        div_start = 1'b1;
        div_num   = NumW'({matches_q, 16'h0});
        div_den   = (ng_q == '0) ? UniW'(1) : UniW'(ng_q);
      end
      default: ;
    endcase
  end

  bsi_div #(.NumW(NumW), .DenW(UniW), .QuotW(RatioW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quot_o(quot)
  );

  assign q_pair = disj_q ? '0 : ((UniW'(inter_q) >= uni_q) ? RatioOne : quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= ThresholdReset;
      nt_q        <= '0;
      ng_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      set_q       <= 1'b0;
      sum_q       <= '0;
      scored_q    <= '0;
      matches_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (iou_threshold_we_i) begin
        thr_q <= iou_threshold_i;
      end
      if (cmd_i.op == OpEmit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OpLoad: begin
          if (t_we) nt_q <= nt_q + CntW'(1);
          if (g_we) ng_q <= ng_q + CntW'(1);
        end
        OpEvalInit: begin
          set_q <= 1'b0;
          i_q   <= '0;
        end
        OpSortRdi: j_q <= i_q + CntW'(1);
        OpSortCmp: j_q <= j_next;
        OpSortWb:  i_q <= i_q + CntW'(1);
        OpNextSet: begin
          set_q <= 1'b1;
          i_q   <= '0;
        end
        OpPairInit: begin
          i_q       <= '0;
          sum_q     <= '0;
          scored_q  <= '0;
          matches_q <= '0;
        end
        OpPairSkip: i_q <= i_q + CntW'(1);
        OpPairAcc: begin
          i_q      <= i_q + CntW'(1);
          sum_q    <= sum_q + SumW'(q_pair);
          scored_q <= scored_q + CntW'(1);
          if (q_pair > thr_q && cls_eq_q) begin
            matches_q <= matches_q + CntW'(1);
          end
        end
        OpEmit: begin
          nt_q <= '0;
          ng_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpSortCap: cur_q <= rd;
      OpSortCmp: if (swap) cur_q <= rd;
      OpPairGeo: begin
        empty_q  <= fld(g_rd, 1) == '1;
        disj_q   <= (x1 > x2) || (y1 > y2);
        cls_eq_q <= t_rd[EntW-1 -: ClassW] == g_rd[EntW-1 -: ClassW];
        iw_q     <= span_f(x1, x2);
        ih_q     <= span_f(y1, y2);
        aw_q     <= span_f(fld(t_rd, 0), fld(t_rd, 2));
        ah_q     <= span_f(fld(t_rd, 1), fld(t_rd, 3));
        bw_q     <= span_f(fld(g_rd, 0), fld(g_rd, 2));
        bh_q     <= span_f(fld(g_rd, 1), fld(g_rd, 3));
      end
      OpPairMul: begin
        inter_q <= AreaW'(iw_q) * AreaW'(ih_q);
        aa_q    <= AreaW'(aw_q) * AreaW'(ah_q);
        ab_q    <= AreaW'(bw_q) * AreaW'(bh_q);
      end
      OpPairUni: uni_q <= UniW'(aa_q) + UniW'(ab_q) - UniW'(inter_q);
      OpFinRec:  mean_q <= quot;
      OpFinPrec: rec_q <= quot;
      OpEmit: begin
        o_mean_q   <= mean_q;
        o_rec_q    <= rec_q;
        o_prec_q   <= quot;
        o_match_q  <= matches_q;
        o_scored_q <= scored_q;
      end
      default: ;
    endcase
  end

  assign status_o.sort_more = (i_q + CntW'(1)) < n_sel;
  assign status_o.j_last    = j_next >= n_sel;
  assign status_o.first_set = !set_q;
  assign status_o.pair_more = i_q < pairs;
  assign status_o.empty     = empty_q;
  assign status_o.div_busy  = div_busy;
  assign status_o.out_block = out_valid_q && out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign mean_iou_o        = o_mean_q;
  assign recall_ratio_o    = o_rec_q;
  assign precision_ratio_o = o_prec_q;
  assign match_count_o     = o_match_q;
  assign scored_pairs_o    = o_scored_q;

endmodule

@@ hw/rtl/bsi_ctrl.sv @@
module bsi_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [bsi_pkg::ModeW-1:0] mode_i,
  input  bsi_pkg::dp_status_t       status_i,
  output bsi_pkg::dp_cmd_t          cmd_o,
  output logic                      in_stall_o
);
  import bsi_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OpNone;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          unique case (mode_e'(mode_i))
            ModeTruth, ModeGuess: cmd_o.op = OpLoad;
            ModeEval: begin
              cmd_o.op = OpEvalInit;
              state_d  = StSortChk;
            end
            default: ;
          endcase
        end
      end
      StSortChk: begin
        if (status_i.sort_more) begin
          cmd_o.op = OpSortRdi;
          state_d  = StSortCap;
        end else if (status_i.first_set) begin
          cmd_o.op = OpNextSet;
        end else begin
          cmd_o.op = OpPairInit;
          state_d  = StPairChk;
        end
      end
      StSortCap: begin
        cmd_o.op = OpSortCap;
        state_d  = StSortCmp;
      end
      StSortCmp: begin
        cmd_o.op = OpSortCmp;
        if (status_i.j_last) state_d = StSortWb;
      end
      StSortWb: begin
        cmd_o.op = OpSortWb;
        state_d  = StSortChk;
      end
      StPairChk: begin
        if (status_i.pair_more) begin
          cmd_o.op = OpPairRd;
          state_d  = StPairGeo;
        end else begin
          cmd_o.op = OpFinMean;
          state_d  = StDivMean;
        end
      end
      StPairGeo: begin
        cmd_o.op = OpPairGeo;
        state_d  = StPairMul;
      end
      StPairMul: begin
        cmd_o.op = OpPairMul;
        state_d  = StPairUni;
      end
      StPairUni: begin
        cmd_o.op = OpPairUni;
        state_d  = StPairDivSt;
      end
      StPairDivSt: begin
        if (status_i.empty) begin
          cmd_o.op = OpPairSkip;
          state_d  = StPairChk;
        end else begin
          cmd_o.op = OpPairDivSt;
          state_d  = StPairDiv;
        end
      end
      StPairDiv: begin
        if (!status_i.div_busy) begin
          cmd_o.op = OpPairAcc;
          state_d  = StPairChk;
        end
      end
      StDivMean: begin
        if (!status_i.div_busy) begin
          cmd_o.op = OpFinRec;
          state_d  = StDivRec;
        end
      end
      StDivRec: begin
        if (!status_i.div_busy) begin
          cmd_o.op = OpFinPrec;
          state_d  = StDivPrec;
        end
      end
      StDivPrec: begin
        if (!status_i.div_busy && !status_i.out_block) begin
          cmd_o.op = OpEmit;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o = state_q != StIdle;

endmodule

@@ hw/rtl/box_set_iou_evaluation.sv @@
// Box-set IoU evaluation.
// Input channel (in_valid_i / in_stall_o) carries one transaction per box:
// mode 0 loads a ground-truth box, mode 1 a predicted box, mode 2 evaluates,
// mode 3 is taken and ignored. Loads do not stall the input; boxes beyond
// MaxBoxes per set are dropped.
// An evaluate transaction sorts both stores by x_min (exchange sort through a
// single RAM read port), then scores each rank pair with one bit-serial
// divide, skipping pairs whose predicted y_min is all ones, and finishes
// with three more divides of the same length.
// One result transaction (out_valid_o / out_stall_i) follows each evaluate.
// The result sits in an output register; new loads are taken while it waits,
// and a following evaluate holds before emitting until the register frees.
// Reset empties both stores, clears out_valid_o and sets the threshold to 0.4.
// iou_threshold_we_i writes the threshold; write only while idle, the block has no guard.
module box_set_iou_evaluation #(
  parameter int unsigned MaxBoxes  = bsi_pkg::MaxBoxesDef,
  parameter int unsigned CoordBits = bsi_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bsi_pkg::ModeW-1:0]     mode_i,
  input  logic [bsi_pkg::ClassW-1:0]    class_id_i,
  input  logic signed [CoordBits-1:0]   x_min_i,
  input  logic signed [CoordBits-1:0]   y_min_i,
  input  logic signed [CoordBits-1:0]   x_max_i,
  input  logic signed [CoordBits-1:0]   y_max_i,
  input  logic                          iou_threshold_we_i,
  input  logic [bsi_pkg::RatioW-1:0]    iou_threshold_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bsi_pkg::RatioW-1:0]    mean_iou_o,
  output logic [bsi_pkg::RatioW-1:0]    recall_ratio_o,
  output logic [bsi_pkg::RatioW-1:0]    precision_ratio_o,
  output logic [$clog2(MaxBoxes+1)-1:0] match_count_o,
  output logic [$clog2(MaxBoxes+1)-1:0] scored_pairs_o
);
  import bsi_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bsi_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .mode_i, .status_i(status), .cmd_o(cmd), .in_stall_o
  );

  bsi_datapath #(.MaxBoxes(MaxBoxes), .CoordBits(CoordBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .mode_i, .class_id_i,
    .x_min_i, .y_min_i, .x_max_i, .y_max_i, .iou_threshold_we_i, .iou_threshold_i,
    .out_stall_i, .out_valid_o, .mean_iou_o, .recall_ratio_o, .precision_ratio_o,
    .match_count_o, .scored_pairs_o
  );

endmodule

@@ hw/rtl/bsi_checker.sv @@
module bsi_checker #(
  parameter int unsigned MaxBoxes = bsi_pkg::MaxBoxesDef
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bsi_pkg::RatioW-1:0]    mean_iou_o,
  input logic [bsi_pkg::RatioW-1:0]    recall_ratio_o,
  input logic [bsi_pkg::RatioW-1:0]    precision_ratio_o,
  input logic [$clog2(MaxBoxes+1)-1:0] match_count_o,
  input logic [$clog2(MaxBoxes+1)-1:0] scored_pairs_o
);
  import bsi_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> match_count_o <= scored_pairs_o)
    else $error("more matches than scored pairs");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mean_iou_o <= RatioOne && recall_ratio_o <= RatioOne
                    && precision_ratio_o <= RatioOne)
    else $error("ratio above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_count_o == '0 |-> recall_ratio_o == '0
                                          && precision_ratio_o == '0)
    else $error("nonzero ratio without matches");

endmodule

bind box_set_iou_evaluation bsi_checker #(.MaxBoxes(MaxBoxes)) u_bsi_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .mean_iou_o(mean_iou_o), .recall_ratio_o(recall_ratio_o),
  .precision_ratio_o(precision_ratio_o), .match_count_o(match_count_o),
  .scored_pairs_o(scored_pairs_o)
);

@@ sim/box_set_iou_evaluation_test.sv @@
module box_set_iou_evaluation_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bsi_pkg::*;

  localparam int unsigned NBox = MaxBoxesDef;
  localparam int unsigned CW = CoordBitsDef;
  localparam int unsigned CntW = $clog2(NBox + 1);

  typedef struct packed {
    mode_e mode;
    logic [ClassW-1:0] cls;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
  } box_req_t;

  typedef struct packed {
    logic [RatioW-1:0] mean;
    logic [RatioW-1:0] rec;
    logic [RatioW-1:0] prec;
    logic [CntW-1:0] hits;
    logic [CntW-1:0] scored;
  } score_t;

  typedef struct {
    box_req_t req;
    logic check_fixed;
    score_t fixed;
  } plan_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [ModeW-1:0] mode_i;
  logic [ClassW-1:0] class_id_i;
  logic signed [CW-1:0] x_min_i, y_min_i, x_max_i, y_max_i;
  logic iou_threshold_we_i;
  logic [RatioW-1:0] iou_threshold_i;
  logic out_valid_o, out_stall_i;
  logic [RatioW-1:0] mean_iou_o, recall_ratio_o, precision_ratio_o;
  logic [CntW-1:0] match_count_o, scored_pairs_o;

  box_set_iou_evaluation i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .class_id_i,
    .x_min_i, .y_min_i, .x_max_i, .y_max_i, .iou_threshold_we_i,
    .iou_threshold_i, .out_valid_o, .out_stall_i, .mean_iou_o,
    .recall_ratio_o, .precision_ratio_o, .match_count_o, .scored_pairs_o
  );

  int signed truth_box[NBox][4];
  logic [ClassW-1:0] truth_cls[NBox];
  int signed guess_box[NBox][4];
  logic [ClassW-1:0] guess_cls[NBox];
  int unsigned truth_n, guess_n;
  logic [RatioW-1:0] thresh;

  score_t pending_scores[$];
  int unsigned errors;
  bit drain_phase;
  bit tx_idle_on, rx_idle_on;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #400ms;
    $display("box_set_iou_evaluation_test NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint span_of(int signed lo, int signed hi);
    longint d;
    d = longint'(hi) - longint'(lo);
    return (d < 0 ? -d : d) + 1;
  endfunction

  function automatic int unsigned box_overlap(int signed a[4], int signed b[4]);
    int signed ix0, iy0, ix1, iy1;
    longint unsigned inter, uni;
    ix0 = a[0] > b[0] ? a[0] : b[0];
    iy0 = a[1] > b[1] ? a[1] : b[1];
    ix1 = a[2] < b[2] ? a[2] : b[2];
    iy1 = a[3] < b[3] ? a[3] : b[3];
    if (ix0 > ix1 || iy0 > iy1) return 0;
    inter = span_of(ix0, ix1) * span_of(iy0, iy1);
    uni = span_of(a[0], a[2]) * span_of(a[1], a[3])
        + span_of(b[0], b[2]) * span_of(b[1], b[3]) - inter;
    if (inter >= uni) return 65536;
    return int'((inter << 16) / uni);
  endfunction

  task automatic sort_truth();
    int signed t;
    logic [ClassW-1:0] c;
    for (int i = 0; i + 1 < truth_n; i++)
      for (int j = i + 1; j < truth_n; j++)
        if (truth_box[i][0] < truth_box[j][0]) begin
          for (int k = 0; k < 4; k++) begin
            t = truth_box[i][k]; truth_box[i][k] = truth_box[j][k]; truth_box[j][k] = t;
          end
          c = truth_cls[i]; truth_cls[i] = truth_cls[j]; truth_cls[j] = c;
        end
  endtask

  task automatic sort_guess();
    int signed t;
    logic [ClassW-1:0] c;
    for (int i = 0; i + 1 < guess_n; i++)
      for (int j = i + 1; j < guess_n; j++)
        if (guess_box[i][0] < guess_box[j][0]) begin
          for (int k = 0; k < 4; k++) begin
            t = guess_box[i][k]; guess_box[i][k] = guess_box[j][k]; guess_box[j][k] = t;
          end
          c = guess_cls[i]; guess_cls[i] = guess_cls[j]; guess_cls[j] = c;
        end
  endtask

  task automatic predict_scores(input box_req_t r, output bit emits, output score_t s);
    int unsigned pairs, hits, scored, q, d;
    longint unsigned sum;
    emits = 1'b0;
    s = '0;
    case (r.mode)
      ModeTruth: begin
        if (truth_n < NBox) begin
          truth_box[truth_n] = '{r.x0, r.y0, r.x1, r.y1};
          truth_cls[truth_n] = r.cls;
          truth_n++;
        end
      end
      ModeGuess: begin
        if (guess_n < NBox) begin
          guess_box[guess_n] = '{r.x0, r.y0, r.x1, r.y1};
          guess_cls[guess_n] = r.cls;
          guess_n++;
        end
      end
      ModeEval: begin
        sort_truth();
        sort_guess();
        pairs = truth_n < guess_n ? truth_n : guess_n;
        hits = 0; scored = 0; sum = 0;
        for (int i = 0; i < pairs; i++) begin
          if (guess_box[i][1] == -1) continue;
          q = box_overlap(truth_box[i], guess_box[i]);
          sum += q;
          scored++;
          if (q > thresh && truth_cls[i] == guess_cls[i]) hits++;
        end
        d = scored ? scored : 1;
        s.mean = RatioW'(sum / d);
        d = truth_n ? truth_n : 1;
        s.rec = RatioW'((longint'(hits) << 16) / d);
        d = guess_n ? guess_n : 1;
        s.prec = RatioW'((longint'(hits) << 16) / d);
        s.hits = CntW'(hits);
        s.scored = CntW'(scored);
        truth_n = 0;
        guess_n = 0;
        emits = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_box(input box_req_t r, input bit use_fixed, input score_t fixed);
    bit emits;
    score_t s;
    if (tx_idle_on && !drain_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= r.mode;
    class_id_i <= r.cls;
    x_min_i <= r.x0;
    y_min_i <= r.y0;
    x_max_i <= r.x1;
    y_max_i <= r.y1;
    do @(posedge clk_i); while (in_stall_o);
    predict_scores(r, emits, s);
    if (emits) begin
      if (use_fixed && s != fixed) report_mismatch("directed row", 0, 1);
      pending_scores.push_back(s);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_scores.size() != 0) @(negedge clk_i);
    repeat (5000) @(negedge clk_i);
  endtask

  task automatic set_threshold(input logic [RatioW-1:0] v);
    wait_quiet();
    iou_threshold_we_i <= 1'b1;
    iou_threshold_i <= v;
    @(negedge clk_i);
    iou_threshold_we_i <= 1'b0;
    thresh = v;
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(CW - 1){1'b0}}};
      1: return {1'b0, {(CW - 1){1'b1}}};
      2: return CW'($urandom);
      default: return CW'(int'($urandom_range(0, 80)) - 20);
    endcase
  endfunction

  function automatic box_req_t rand_box(input mode_e m, input int signed cx,
                                        input int signed cy);
    box_req_t r;
    r.mode = m;
    r.cls = ($urandom_range(0, 7) == 0) ? ClassW'($urandom) : ClassW'($urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) begin
      r.x0 = rand_coord(); r.y0 = rand_coord(); r.x1 = rand_coord(); r.y1 = rand_coord();
    end else begin
      r.x0 = CW'(cx + int'($urandom_range(0, 6)) - 3);
      r.y0 = CW'(cy + int'($urandom_range(0, 6)) - 3);
      r.x1 = CW'(cx + int'($urandom_range(4, 20)));
      r.y1 = CW'(cy + int'($urandom_range(4, 20)));
    end
    if (m == ModeGuess && $urandom_range(0, 11) == 0) r.y0 = '1;
    return r;
  endfunction

  task automatic send_frame(input int unsigned nt, input int unsigned ng);
    int signed cx[NBox];
    int signed cy[NBox];
    int unsigned it, ig;
    score_t none;
    none = '0;
    for (int k = 0; k < NBox; k++) begin
      cx[k] = int'($urandom_range(0, 2000)) - 1000;
      cy[k] = int'($urandom_range(0, 2000)) - 1000;
    end
    it = 0; ig = 0;
    while (it < nt || ig < ng) begin
      if (it < nt && (ig >= ng || $urandom_range(0, 1))) begin
        send_box(rand_box(ModeTruth, cx[it % NBox], cy[it % NBox]), 0, none);
        it++;
      end else begin
        send_box(rand_box(ModeGuess, cx[ig % NBox], cy[ig % NBox]), 0, none);
        ig++;
      end
      if ($urandom_range(0, 40) == 0) send_box('{ModeNone, ClassW'($urandom),
        CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom)}, 0, none);
    end
    send_box('{ModeEval, ClassW'($urandom), CW'($urandom), CW'($urandom),
      CW'($urandom), CW'($urandom)}, 0, none);
  endtask

  initial begin
    score_t got, want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = '{mean_iou_o, recall_ratio_o, precision_ratio_o, match_count_o,
                scored_pairs_o};
        if (pending_scores.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = pending_scores.pop_front();
          if (got.mean != want.mean) report_mismatch("mean_iou", got.mean, want.mean);
          if (got.rec != want.rec) report_mismatch("recall_ratio", got.rec, want.rec);
          if (got.prec != want.prec)
            report_mismatch("precision_ratio", got.prec, want.prec);
          if (got.hits != want.hits) report_mismatch("match_count", got.hits, want.hits);
          if (got.scored != want.scored)
            report_mismatch("scored_pairs", got.scored, want.scored);
        end
      end
    end
  end

  initial begin
    int n;
    out_stall_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if (!drain_phase && rx_idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(negedge clk_i);
    end
  end

  localparam logic signed [CW-1:0] CMin = {1'b1, {(CW - 1){1'b0}}};
  localparam logic signed [CW-1:0] CMax = {1'b0, {(CW - 1){1'b1}}};
  localparam score_t Zero = '0;
  localparam score_t OnePerfect = '{RatioOne, RatioOne, RatioOne, CntW'(1), CntW'(1)};

  plan_row_t plan[] = '{
    '{'{ModeEval, 8'd0, '0, '0, '0, '0}, 1, Zero},
    '{'{ModeTruth, 8'd3, 15'sd0, 15'sd0, 15'sd9, 15'sd9}, 0, Zero},
    '{'{ModeGuess, 8'd3, 15'sd0, 15'sd0, 15'sd9, 15'sd9}, 0, Zero},
    '{'{ModeEval, 8'd0, '0, '0, '0, '0}, 1, OnePerfect},
    '{'{ModeTruth, 8'hFF, CMin, CMin, CMax, CMax}, 0, Zero},
    '{'{ModeGuess, 8'hFF, CMax, CMax, CMin, CMin}, 0, Zero},
    '{'{ModeEval, 8'd0, '0, '0, '0, '0}, 0, Zero},
    '{'{ModeTruth, 8'd1, 15'sd0, 15'sd0, 15'sd4, 15'sd4}, 0, Zero},
    '{'{ModeGuess, 8'd1, 15'sd100, 15'sd100, 15'sd104, 15'sd104}, 0, Zero},
    '{'{ModeEval, 8'd0, '0, '0, '0, '0}, 1,
      '{17'd0, 17'd0, 17'd0, CntW'(0), CntW'(1)}},
    '{'{ModeTruth, 8'd1, 15'sd0, 15'sd0, 15'sd4, 15'sd4}, 0, Zero},
    '{'{ModeGuess, 8'd1, 15'sd0, -15'sd1, 15'sd4, 15'sd4}, 0, Zero},
    '{'{ModeEval, 8'd0, '0, '0, '0, '0}, 1, Zero},
    '{'{ModeNone, 8'hAA, CMin, CMax, CMin, CMax}, 0, Zero},
    '{'{ModeTruth, 8'd2, 15'sd5, 15'sd0, 15'sd1, 15'sd3}, 0, Zero},
    '{'{ModeTruth, 8'd2, 15'sd20, 15'sd0, 15'sd30, 15'sd3}, 0, Zero},
    '{'{ModeTruth, 8'd4, 15'sd20, 15'sd1, 15'sd25, 15'sd8}, 0, Zero},
    '{'{ModeGuess, 8'd2, 15'sd20, 15'sd0, 15'sd30, 15'sd3}, 0, Zero},
    '{'{ModeGuess, 8'd4, 15'sd20, 15'sd2, 15'sd24, 15'sd8}, 0, Zero},
    '{'{ModeEval, 8'd0, '0, '0, '0, '0}, 0, Zero},
    '{'{ModeGuess, 8'd7, 15'sd1, 15'sd1, 15'sd2, 15'sd2}, 0, Zero},
    '{'{ModeEval, 8'd0, '0, '0, '0, '0}, 1, Zero}
  };

  initial begin
    errors = 0;
    truth_n = 0;
    guess_n = 0;
    thresh = ThresholdReset;
    drain_phase = 1'b0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = '0;
    class_id_i = '0;
    x_min_i = '0;
    y_min_i = '0;
    x_max_i = '0;
    y_max_i = '0;
    iou_threshold_we_i = 1'b0;
    iou_threshold_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[k]) send_box(plan[k].req, plan[k].check_fixed, plan[k].fixed);

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_frame(NBox + 3, NBox + 2);
    set_threshold('0);
    for (int f = 0; f < 12; f++) send_frame($urandom_range(0, 8), $urandom_range(0, 8));
    set_threshold(RatioOne);
    for (int f = 0; f < 12; f++) send_frame($urandom_range(1, 8), $urandom_range(1, 8));
    set_threshold(17'h1FFFF);
    for (int f = 0; f < 6; f++) send_frame($urandom_range(1, 6), $urandom_range(1, 6));
    set_threshold(RatioW'($urandom_range(0, 65536)));
    for (int f = 0; f < 30; f++) begin
      if (f == 15) wait_quiet();
      send_frame($urandom_range(0, 10), $urandom_range(0, 10));
    end
    set_threshold(ThresholdReset);
    drain_phase = 1'b1;
    for (int f = 0; f < 20; f++) send_frame($urandom_range(1, 10), $urandom_range(1, 10));

    wait_quiet();
    if (errors == 0) begin
      $display("box_set_iou_evaluation_test OK");
    end else begin
      $display("box_set_iou_evaluation_test NOT OK");
    end
    $finish;
  end
endmodule
